// File: src/lowest_free_room_allocator_top_assert.svh
// ----------------------------------------------------------------------------
// Lowest free room allocator assertion macros
// Shared property shapes for the allocator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef LOWEST_FREE_ROOM_ALLOCATOR_TOP_ASSERT_SVH
`define LOWEST_FREE_ROOM_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFRA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LFRA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// File: src/lfra_pkg.sv
// ----------------------------------------------------------------------------
// Lowest free room allocator package
// Field widths, limits and the types shared by the room cells and the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lfra_pkg;

    localparam int TIME_W = 40;
    localparam int CNT_W  = 24;
    localparam int IN_W   = 20;
    localparam int ROOM_W = 7;
    localparam int CFG_W  = 8;

    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};
    localparam logic [CNT_W-1:0]  COUNT_MAX = {CNT_W{1'b1}};
    localparam logic [CFG_W-1:0]  CFG_RESET = 8'd128;

    typedef struct packed {
        logic [TIME_W-1:0] free_at;
        logic [CNT_W-1:0]  count;
    } cell_data_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

// File: src/lowest_free_room_allocator_top.sv
// ----------------------------------------------------------------------------
// Lowest free room allocator top level
// Assigns each job to the lowest free room, or else to the earliest freeing
// room, and reports the running busiest room.
// ----------------------------------------------------------------------------
// An accepted job passes through the accept step, a scan in which the ring
// of room cells rotates once past the scan point, a step that writes the
// chosen room, and a step that moves the result into the output register,
// which waits while the output register is still full; only then can the
// next job be taken. A rejected job skips the scan and the write. A new job
// is accepted while the previous result still waits in the output register.
// Reset clears every room at once, so no clearing pass follows it.
`timescale 1ns / 1ps

`include "lowest_free_room_allocator_top_assert.svh"

module lowest_free_room_allocator_top #(
    parameter int NUM_ROOMS = 128
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [lfra_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lfra_pkg::IN_W-1:0]          start_time,
    input  logic [lfra_pkg::IN_W-1:0]          end_time,
    input  logic                               last_job,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [lfra_pkg::ROOM_W-1:0]        room,
    output logic [lfra_pkg::TIME_W-1:0]        actual_start,
    output logic [lfra_pkg::TIME_W-1:0]        actual_end,
    output logic [lfra_pkg::ROOM_W-1:0]        busiest_room,
    output logic [lfra_pkg::CNT_W-1:0]         busiest_count,
    output logic                               rejected,
    output logic                               last_result
);

    localparam int RW = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1;
    localparam int NW = (RW + 1 > lfra_pkg::CFG_W) ? RW + 1 : lfra_pkg::CFG_W;
    localparam logic [RW-1:0] LAST_IDX = RW'(NUM_ROOMS - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [lfra_pkg::CFG_W-1:0] cfg_reg;
    logic [RW-1:0] scan_cnt_reg;
    logic [lfra_pkg::IN_W-1:0] st_reg, en_reg;
    logic last_reg;
    logic prev_valid_reg;
    logic [lfra_pkg::IN_W-1:0] prev_start_reg;
    logic found_reg;
    logic [RW-1:0] free_idx_reg;
    logic [lfra_pkg::CNT_W-1:0] free_cnt_reg;
    logic [RW-1:0] min_idx_reg;
    logic [lfra_pkg::TIME_W-1:0] min_at_reg;
    logic [lfra_pkg::CNT_W-1:0] min_cnt_reg;
    logic [RW-1:0] best_room_reg;
    logic [lfra_pkg::CNT_W-1:0] best_count_reg;
    logic [RW-1:0] res_room_reg;
    logic [lfra_pkg::TIME_W-1:0] res_start_reg, res_end_reg;
    logic res_rej_reg;
    logic out_valid_reg;
    logic [lfra_pkg::ROOM_W-1:0] out_room_reg, out_best_room_reg;
    logic [lfra_pkg::TIME_W-1:0] out_start_reg, out_end_reg;
    logic [lfra_pkg::CNT_W-1:0] out_best_count_reg;
    logic out_rej_reg, out_last_reg;

    logic accept, reject_in, in_scan, out_free;
    logic [NW-1:0] cfg_ext, n_act;
    lfra_pkg::cell_data_t cell_q [NUM_ROOMS];
    lfra_pkg::cell_data_t head, wr_data;
    lfra_pkg::cell_ctrl_t cell_ctrl [NUM_ROOMS];
    logic [RW-1:0] pick;
    logic [lfra_pkg::TIME_W-1:0] a_start, a_end;
    logic [lfra_pkg::TIME_W:0] a_sum;
    logic [lfra_pkg::IN_W-1:0] dur;
    logic [lfra_pkg::CNT_W-1:0] pick_cnt, new_cnt;
    logic new_best;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign reject_in = (prev_valid_reg && (start_time <= prev_start_reg))
                       || (end_time <= start_time);
    assign in_scan   = (state_reg == ST_SCAN) && (NW'(scan_cnt_reg) < n_act);
    assign out_free  = !out_valid_reg || out_ready;
    assign head      = cell_q[0];

    always_comb
    begin
        cfg_ext = NW'(cfg_reg);
        if (cfg_reg == '0)
        begin
            n_act = NW'(1);
        end
        else if (cfg_ext > NW'(NUM_ROOMS))
        begin
            n_act = NW'(NUM_ROOMS);
        end
        else
        begin
            n_act = cfg_ext;
        end
    end

    always_comb
    begin
        pick     = found_reg ? free_idx_reg : min_idx_reg;
        a_start  = found_reg ? lfra_pkg::TIME_W'(st_reg) : min_at_reg;
        pick_cnt = found_reg ? free_cnt_reg : min_cnt_reg;
        dur      = en_reg - st_reg;
        a_sum    = {1'b0, a_start} + (lfra_pkg::TIME_W + 1)'(dur);
        a_end    = a_sum[lfra_pkg::TIME_W] ? lfra_pkg::TIME_MAX
                                           : a_sum[lfra_pkg::TIME_W-1:0];
        new_cnt  = (pick_cnt == lfra_pkg::COUNT_MAX) ? pick_cnt : pick_cnt + 1'b1;
        new_best = (new_cnt > best_count_reg)
                   || ((new_cnt == best_count_reg) && (pick < best_room_reg));
        wr_data.free_at = a_end;
        wr_data.count   = new_cnt;
    end

    genvar gi;
    generate
        for (gi = 0; gi < NUM_ROOMS; gi++)
        begin : g_cell
            localparam int NXT = (gi + 1) % NUM_ROOMS;

            assign cell_ctrl[gi].shift = (state_reg == ST_SCAN);
            assign cell_ctrl[gi].load  = (state_reg == ST_UPDATE) && (pick == RW'(gi));

            lfra_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl[gi]),
                .nbr_data (cell_q[NXT]),
                .wr_data  (wr_data),
                .data     (cell_q[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = reject_in ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cfg_reg        <= lfra_pkg::CFG_RESET;
            prev_valid_reg <= 1'b0;
            prev_start_reg <= '0;
            best_room_reg  <= '0;
            best_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            scan_cnt_reg   <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                cfg_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
                if (!reject_in)
                begin
                    prev_valid_reg <= 1'b1;
                    prev_start_reg <= start_time;
                end
            end
            if (state_reg == ST_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
                if (in_scan && !found_reg && (head.free_at <= lfra_pkg::TIME_W'(st_reg)))
                begin
                    found_reg <= 1'b1;
                end
            end
            if ((state_reg == ST_UPDATE) && new_best)
            begin
                best_room_reg  <= pick;
                best_count_reg <= new_cnt;
            end
            if ((state_reg == ST_RESULT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_reg        <= start_time;
            en_reg        <= end_time;
            last_reg      <= last_job;
            res_rej_reg   <= reject_in;
            res_room_reg  <= '0;
            res_start_reg <= '0;
            res_end_reg   <= '0;
        end
        if (in_scan)
        begin
            if (!found_reg && (head.free_at <= lfra_pkg::TIME_W'(st_reg)))
            begin
                free_idx_reg <= scan_cnt_reg;
                free_cnt_reg <= head.count;
            end
            if ((scan_cnt_reg == '0) || (head.free_at < min_at_reg))
            begin
                min_idx_reg <= scan_cnt_reg;
                min_at_reg  <= head.free_at;
                min_cnt_reg <= head.count;
            end
        end
        if (state_reg == ST_UPDATE)
        begin
            res_room_reg  <= pick;
            res_start_reg <= a_start;
            res_end_reg   <= a_end;
        end
        if ((state_reg == ST_RESULT) && out_free)
        begin
            out_room_reg       <= lfra_pkg::ROOM_W'(res_room_reg);
            out_start_reg      <= res_start_reg;
            out_end_reg        <= res_end_reg;
            out_best_room_reg  <= lfra_pkg::ROOM_W'(best_room_reg);
            out_best_count_reg <= best_count_reg;
            out_rej_reg        <= res_rej_reg;
            out_last_reg       <= last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign room          = out_room_reg;
    assign actual_start  = out_start_reg;
    assign actual_end    = out_end_reg;
    assign busiest_room  = out_best_room_reg;
    assign busiest_count = out_best_count_reg;
    assign rejected      = out_rej_reg;
    assign last_result   = out_last_reg;

    `LFRA_ASSERT_NEXT(a_scan_ends, clk, rst_n,
        (state_reg == ST_SCAN) && (scan_cnt_reg == LAST_IDX), state_reg == ST_UPDATE)
    `LFRA_ASSERT_NEXT(a_reject_skips_scan, clk, rst_n,
        accept && reject_in, (state_reg == ST_RESULT) && res_rej_reg)
    `LFRA_ASSERT_NEXT(a_best_never_drops, clk, rst_n,
        state_reg == ST_UPDATE, best_count_reg >= $past(best_count_reg))
    `LFRA_ASSERT_NOW(a_pick_in_range, clk, rst_n,
        state_reg == ST_UPDATE, NW'(pick) < n_act)

endmodule

// File: src/lfra_cell.sv
// ----------------------------------------------------------------------------
// Lowest free room allocator room cell
// Holds one room's free-at time and job count and passes them to its
// neighbor while the ring rotates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lfra_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  lfra_pkg::cell_ctrl_t ctrl,
    input  lfra_pkg::cell_data_t nbr_data,
    input  lfra_pkg::cell_data_t wr_data,
    output lfra_pkg::cell_data_t data
);

    lfra_pkg::cell_data_t data_reg;
    lfra_pkg::cell_data_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = nbr_data;
        end
        else if (ctrl.load)
        begin
            data_next = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// Lowest free room allocator testbench
// Drives a typed job table, then randomized job streams, mostly in ascending
// start order, through a series of room counts. It checks every result
// transfer against a typed result or the in-bench room allocation predictor,
// with random idling on both channels and a long back-pressure stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int ROOMS        = 128;
    localparam int IN_MAX       = (1 << lfra_pkg::IN_W) - 1;
    localparam int START_BUDGET = 1040000;
    localparam int PHASES       = 10;
    localparam int PHASE_JOBS   = 95;
    localparam int RANDOM_JOBS  = PHASES * PHASE_JOBS;
    localparam int HOLD_CYCLES  = 2000;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef enum logic {ROW_JOB, ROW_CFG} row_kind_t;

    typedef struct packed {
        logic [lfra_pkg::ROOM_W-1:0] room;
        logic [lfra_pkg::TIME_W-1:0] start_at;
        logic [lfra_pkg::TIME_W-1:0] end_at;
        logic [lfra_pkg::ROOM_W-1:0] top_room;
        logic [lfra_pkg::CNT_W-1:0]  top_count;
        logic                        rejected;
        logic                        last;
    } alloc_t;

    typedef struct packed {
        row_kind_t                   kind;
        logic [lfra_pkg::CFG_W-1:0]  cfg;
        logic [lfra_pkg::IN_W-1:0]   req_start;
        logic [lfra_pkg::IN_W-1:0]   req_end;
        logic                        req_last;
        logic                        typed;
        alloc_t                      want;
    } dir_row_t;

    localparam alloc_t NO_TYPED = '0;

    localparam dir_row_t DIRECTED [0:21] = '{
        '{ROW_JOB, 8'd0, 20'd0, 20'd0, 1'b0, 1'b1,
          '{7'd0, 40'd0, 40'd0, 7'd0, 24'd0, 1'b1, 1'b0}},
        '{ROW_JOB, 8'd0, 20'd0, 20'd1, 1'b0, 1'b1,
          '{7'd0, 40'd0, 40'd1, 7'd0, 24'd1, 1'b0, 1'b0}},
        '{ROW_JOB, 8'd0, 20'd0, 20'd5, 1'b1, 1'b1,
          '{7'd0, 40'd0, 40'd0, 7'd0, 24'd1, 1'b1, 1'b1}},
        '{ROW_JOB, 8'd0, 20'hFFFFF, 20'd0, 1'b0, 1'b1,
          '{7'd0, 40'd0, 40'd0, 7'd0, 24'd1, 1'b1, 1'b0}},
        '{ROW_JOB, 8'd0, 20'hFFFFF, 20'hFFFFF, 1'b1, 1'b1,
          '{7'd0, 40'd0, 40'd0, 7'd0, 24'd1, 1'b1, 1'b1}},
        '{ROW_JOB, 8'd0, 20'd1, 20'hFFFFF, 1'b0, 1'b1,
          '{7'd0, 40'd1, 40'hFFFFF, 7'd0, 24'd2, 1'b0, 1'b0}},
        '{ROW_JOB, 8'd0, 20'd2, 20'd3, 1'b0, 1'b1,
          '{7'd1, 40'd2, 40'd3, 7'd0, 24'd2, 1'b0, 1'b0}},
        '{ROW_JOB, 8'd0, 20'd3, 20'd4, 1'b0, 1'b0, NO_TYPED},
        '{ROW_JOB, 8'd0, 20'd4, 20'h55555, 1'b0, 1'b0, NO_TYPED},
        '{ROW_JOB, 8'd0, 20'd5, 20'hAAAAA, 1'b1, 1'b0, NO_TYPED},
        '{ROW_CFG, 8'd2, 20'd0, 20'd0, 1'b0, 1'b0, NO_TYPED},
        '{ROW_JOB, 8'd0, 20'd10, 20'd100, 1'b0, 1'b0, NO_TYPED},
        '{ROW_JOB, 8'd0, 20'd11, 20'd50, 1'b0, 1'b0, NO_TYPED},
        '{ROW_JOB, 8'd0, 20'd12, 20'd20, 1'b0, 1'b0, NO_TYPED},
        '{ROW_JOB, 8'd0, 20'd12, 20'd30, 1'b0, 1'b0, NO_TYPED},
        '{ROW_CFG, 8'd0, 20'd0, 20'd0, 1'b0, 1'b0, NO_TYPED},
        '{ROW_JOB, 8'd0, 20'd13, 20'd14, 1'b0, 1'b0, NO_TYPED},
        '{ROW_JOB, 8'd0, 20'd20, 20'd1020, 1'b0, 1'b0, NO_TYPED},
        '{ROW_CFG, 8'd255, 20'd0, 20'd0, 1'b0, 1'b0, NO_TYPED},
        '{ROW_JOB, 8'd0, 20'd21, 20'd22, 1'b0, 1'b0, NO_TYPED},
        '{ROW_JOB, 8'd0, 20'd22, 20'h7FFFF, 1'b1, 1'b0, NO_TYPED},
        '{ROW_JOB, 8'd0, 20'd30, 20'd25, 1'b0, 1'b0, NO_TYPED}
    };

    localparam logic [lfra_pkg::CFG_W-1:0] PHASE_ROOMS [0:PHASES-1] =
        '{8'd1, 8'd128, 8'd3, 8'd0, 8'd2, 8'd255, 8'd5, 8'd16, 8'd4, 8'd64};

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [lfra_pkg::CFG_W-1:0]     cfg_wr_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_ready;
    logic [lfra_pkg::IN_W-1:0]      start_time = '0;
    logic [lfra_pkg::IN_W-1:0]      end_time = '0;
    logic                           last_job = 1'b0;
    logic                           out_valid;
    logic                           out_ready = 1'b0;
    logic [lfra_pkg::ROOM_W-1:0]    room;
    logic [lfra_pkg::TIME_W-1:0]    actual_start;
    logic [lfra_pkg::TIME_W-1:0]    actual_end;
    logic [lfra_pkg::ROOM_W-1:0]    busiest_room;
    logic [lfra_pkg::CNT_W-1:0]     busiest_count;
    logic                           rejected;
    logic                           last_result;

    logic [lfra_pkg::TIME_W-1:0]    pred_free_at [ROOMS];
    logic [lfra_pkg::CNT_W-1:0]     pred_jobs [ROOMS];
    int                             pred_best_room = 0;
    logic [lfra_pkg::CNT_W-1:0]     pred_best_jobs = '0;
    bit                             pred_seen = 1'b0;
    logic [lfra_pkg::IN_W-1:0]      pred_last_start = '0;
    logic [lfra_pkg::CFG_W-1:0]     pred_rooms_cfg = lfra_pkg::CFG_RESET;

    alloc_t               pending_allocs [$];
    bit                   typed_pending = 1'b0;
    alloc_t               typed_alloc = '0;
    int                   errors = 0;
    int                   cycles = 0;
    int                   snd_idle_pct = 25;
    int                   rcv_idle_pct = 68;
    int                   hold_requests = 0;
    int                   hold_served = 0;
    int                   hold_left = 0;

    lowest_free_room_allocator_top #(
        .NUM_ROOMS(ROOMS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .start_time(start_time),
        .end_time(end_time),
        .last_job(last_job),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .room(room),
        .actual_start(actual_start),
        .actual_end(actual_end),
        .busiest_room(busiest_room),
        .busiest_count(busiest_count),
        .rejected(rejected),
        .last_result(last_result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int rooms_active(input logic [lfra_pkg::CFG_W-1:0] cfg);
        if (cfg == 0)
            return 1;
        if (cfg > ROOMS)
            return ROOMS;
        return int'(cfg);
    endfunction

    function automatic alloc_t allocate_job(input logic [lfra_pkg::IN_W-1:0] s,
                                            input logic [lfra_pkg::IN_W-1:0] e,
                                            input logic l);
        alloc_t                      r;
        int                          n;
        int                          pick;
        int                          i;
        bit                          found;
        logic [lfra_pkg::TIME_W:0]   sum;
        logic [lfra_pkg::TIME_W-1:0] a_start;
        logic [lfra_pkg::TIME_W-1:0] a_end;
        r = '0;
        r.last = l;
        n = rooms_active(pred_rooms_cfg);
        if ((pred_seen && s <= pred_last_start) || e <= s)
        begin
            r.top_room = lfra_pkg::ROOM_W'(pred_best_room);
            r.top_count = pred_best_jobs;
            r.rejected = 1'b1;
            return r;
        end
        pick = 0;
        found = 1'b0;
        for (i = 0; i < n; i++)
        begin
            if (!found && pred_free_at[i] <= lfra_pkg::TIME_W'(s))
            begin
                pick = i;
                found = 1'b1;
            end
        end
        if (found)
            a_start = lfra_pkg::TIME_W'(s);
        else
        begin
            pick = 0;
            for (i = 1; i < n; i++)
                if (pred_free_at[i] < pred_free_at[pick])
                    pick = i;
            a_start = pred_free_at[pick];
        end
        sum = (lfra_pkg::TIME_W+1)'(a_start) + (lfra_pkg::TIME_W+1)'(e - s);
        a_end = (sum > lfra_pkg::TIME_MAX) ? lfra_pkg::TIME_MAX
                                           : sum[lfra_pkg::TIME_W-1:0];
        pred_free_at[pick] = a_end;
        if (pred_jobs[pick] < lfra_pkg::COUNT_MAX)
            pred_jobs[pick] = pred_jobs[pick] + 1'b1;
        if (pred_jobs[pick] > pred_best_jobs ||
            (pred_jobs[pick] == pred_best_jobs && pick < pred_best_room))
        begin
            pred_best_jobs = pred_jobs[pick];
            pred_best_room = pick;
        end
        pred_seen = 1'b1;
        pred_last_start = s;
        r.room = lfra_pkg::ROOM_W'(pick);
        r.start_at = a_start;
        r.end_at = a_end;
        r.top_room = lfra_pkg::ROOM_W'(pred_best_room);
        r.top_count = pred_best_jobs;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        alloc_t got;
        alloc_t want;
        alloc_t pred;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = {room, actual_start, actual_end, busiest_room, busiest_count,
                       rejected, last_result};
                if (pending_allocs.size() == 0)
                begin
                    $display("%0t: result transfer with no job waiting, room %0d",
                             $time, room);
                    errors++;
                end
                else
                begin
                    want = pending_allocs.pop_front();
                    check_field("room", 64'(want.room), 64'(got.room));
                    check_field("actual_start", 64'(want.start_at), 64'(got.start_at));
                    check_field("actual_end", 64'(want.end_at), 64'(got.end_at));
                    check_field("busiest_room", 64'(want.top_room), 64'(got.top_room));
                    check_field("busiest_count", 64'(want.top_count), 64'(got.top_count));
                    check_field("rejected", 64'(want.rejected), 64'(got.rejected));
                    check_field("last_result", 64'(want.last), 64'(got.last));
                end
            end
            if (in_valid && in_ready)
            begin
                pred = allocate_job(start_time, end_time, last_job);
                pending_allocs.push_back(typed_pending ? typed_alloc : pred);
            end
        end
    end

    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_job(input logic [lfra_pkg::IN_W-1:0] s,
                            input logic [lfra_pkg::IN_W-1:0] e, input logic l,
                            input bit typed, input alloc_t want);
        @(negedge clk);
        while ($urandom_range(0, 99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        typed_pending = typed;
        typed_alloc = want;
        start_time <= s;
        end_time <= e;
        last_job <= l;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_allocs.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_rooms(input logic [lfra_pkg::CFG_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        pred_rooms_cfg = value;
    endtask

    task automatic make_random_job(input int sent, output logic [lfra_pkg::IN_W-1:0] s,
                                   output logic [lfra_pkg::IN_W-1:0] e, output logic l);
        int last_s;
        int step_max;
        int span;
        int cand;
        int dur;
        last_s = int'(pred_last_start);
        step_max = ((START_BUDGET - last_s) * 2) / (RANDOM_JOBS - sent + 1);
        if (step_max < 1)
            step_max = 1;
        span = step_max * rooms_active(pred_rooms_cfg);
        if (span > IN_MAX)
            span = IN_MAX;
        cand = last_s + $urandom_range(1, step_max);
        l = ($urandom_range(0, 19) == 0);
        if ($urandom_range(0, 99) < 12 || cand > IN_MAX - 1)
        begin
            if ($urandom_range(0, 1))
            begin
                s = lfra_pkg::IN_W'($urandom_range(0, last_s));
                e = lfra_pkg::IN_W'($urandom_range(0, IN_MAX));
            end
            else
            begin
                s = (cand > IN_MAX) ? lfra_pkg::IN_W'(IN_MAX) : lfra_pkg::IN_W'(cand);
                e = lfra_pkg::IN_W'($urandom_range(0, int'(s)));
            end
        end
        else
        begin
            case ($urandom_range(0, 9))
                0: dur = 1;
                7: dur = $urandom_range(1, IN_MAX);
                8, 9: dur = $urandom_range(1, step_max);
                default: dur = $urandom_range(1, span);
            endcase
            s = lfra_pkg::IN_W'(cand);
            e = (cand + dur > IN_MAX) ? lfra_pkg::IN_W'(IN_MAX)
                                      : lfra_pkg::IN_W'(cand + dur);
        end
    endtask

    initial
    begin
        logic [lfra_pkg::IN_W-1:0] s;
        logic [lfra_pkg::IN_W-1:0] e;
        logic                      l;
        int                        sent;
        foreach (pred_free_at[k])
        begin
            pred_free_at[k] = '0;
            pred_jobs[k] = '0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED[k])
        begin
            if (DIRECTED[k].kind == ROW_CFG)
                write_rooms(DIRECTED[k].cfg);
            else
                send_job(DIRECTED[k].req_start, DIRECTED[k].req_end, DIRECTED[k].req_last,
                         DIRECTED[k].typed, DIRECTED[k].want);
        end

        sent = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            write_rooms(PHASE_ROOMS[p]);
            for (int j = 0; j < PHASE_JOBS; j++)
            begin
                if (sent < RANDOM_JOBS / 3)
                begin
                    snd_idle_pct = 25;
                    rcv_idle_pct = 68;
                end
                else if (sent < 2 * RANDOM_JOBS / 3)
                begin
                    snd_idle_pct = 68;
                    rcv_idle_pct = 25;
                end
                else
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
                if (p == 1 && j == 10)
                    hold_requests++;
                if (p == 4 && j == 50)
                    drain_results();
                make_random_job(sent, s, e, l);
                send_job(s, e, l, 1'b0, NO_TYPED);
                sent++;
            end
        end
        send_job(lfra_pkg::IN_W'(IN_MAX - 1), lfra_pkg::IN_W'(IN_MAX), 1'b1, 1'b0, NO_TYPED);

        drain_results();
        repeat (ROOMS + 8) @(posedge clk);
        errors += pending_allocs.size();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/lfra_pkg.sv
src/lfra_cell.sv
src/lowest_free_room_allocator_top.sv
sim/tb_top.sv
